// ===== rtl/layer_bracket_compositor_assert.svh =====
// Assertion macros for the layer compositor.
// Used by layer_bracket_compositor.sv; expects clk and rst in scope.
`ifndef LAYER_BRACKET_COMPOSITOR_ASSERT_SVH
`define LAYER_BRACKET_COMPOSITOR_ASSERT_SVH

// next-cycle implication, off during reset
`define LBC_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("lbc: %m failed");

// next-cycle implication, also checked across reset
`define LBC_ASSERT_NXT_RST(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("lbc: %m failed");

`endif

// ===== rtl/lbc_pkg.sv =====
// Shared types, constants and functions of the layer compositor.
// No dependencies.
`default_nettype none
package lbc_pkg;

  localparam int CH_W      = 24;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = CH_W + FRAC_BITS;   // divide dividend width
  localparam int WIDE_W    = 2 * CH_W + 3;        // blend sum width
  localparam int LAT       = NUM_W + 2;           // cycles, accept to result

  localparam logic signed [CH_W-1:0] CH_MAX = {1'b0, {(CH_W-1){1'b1}}};
  localparam logic signed [CH_W-1:0] CH_MIN = {1'b1, {(CH_W-1){1'b0}}};
  localparam logic signed [CH_W+1:0] ONE_S  = (CH_W+2)'(1) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_BLEND = 3'd4,
    MODE_SOLID = 3'd5
  } mode_t;

  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [NUM_W-1:0] nq;     // dividend bits out the top, quotient bits in
    logic [CH_W-1:0]  d;
    logic             neg;
    logic             pneg;
    logic             pzero;
    logic             czero;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t    r;
    logic [CH_W:0] t;
    logic [CH_W:0] diff;
    logic       ge;
    r    = s;
    t    = {s.rem, s.nq[NUM_W-1]};
    diff = t - {1'b0, s.d};
    ge   = (t >= {1'b0, s.d});
    r.rem = ge ? diff[CH_W-1:0] : t[CH_W-1:0];
    r.nq  = {s.nq[NUM_W-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [CH_W-1:0] sat_wide(logic signed [WIDE_W-1:0] x);
    if (x > WIDE_W'(CH_MAX)) begin
      return CH_MAX;
    end else if (x < WIDE_W'(CH_MIN)) begin
      return CH_MIN;
    end
    return x[CH_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbc_div.sv =====
// Pipelined restoring divider: p * 2^FRAC_BITS / c, truncated, saturated.
// One quotient bit per stage. Depends on lbc_pkg.
`default_nettype none
module lbc_div import lbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [CH_W-1:0] p,
  input  wire logic signed [CH_W-1:0] c,
  output logic signed [CH_W-1:0]      q
);

  div_st_t          st [NUM_W];
  div_st_t          init;
  logic [CH_W-1:0]  pmag;
  logic [CH_W-1:0]  cmag;
  div_st_t          fin;
  logic [NUM_W-1:0] qn;

  always_comb begin
    pmag       = p[CH_W-1] ? CH_W'(-p) : CH_W'(p);
    cmag       = c[CH_W-1] ? CH_W'(-c) : CH_W'(c);
    init.rem   = '0;
    init.nq    = {pmag, {FRAC_BITS{1'b0}}};
    init.d     = cmag;
    init.neg   = p[CH_W-1] ^ c[CH_W-1];
    init.pneg  = p[CH_W-1];
    init.pzero = (p == '0);
    init.czero = (c == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(init);
      for (int i = 1; i < NUM_W; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  always_comb begin
    fin = st[NUM_W-1];
    qn  = -fin.nq;
    if (fin.czero) begin
      q = fin.pzero ? '0 : (fin.pneg ? CH_MIN : CH_MAX);
    end else if (!fin.neg) begin
      q = (fin.nq > NUM_W'(CH_MAX)) ? CH_MAX : fin.nq[CH_W-1:0];
    end else begin
      q = (fin.nq > (NUM_W'(1) << (CH_W - 1))) ? CH_MIN : qn[CH_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbc_chan.sv =====
// One color channel: add, subtract, multiply, divide, blend or replace.
// Depends on lbc_pkg and lbc_div. Registers advance only on enabled cycles.
`default_nettype none
module lbc_chan import lbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire mode_t                  mode,
  input  wire logic signed [CH_W-1:0] p,
  input  wire logic signed [CH_W-1:0] c,
  input  wire logic signed [CH_W-1:0] a,
  output logic signed [CH_W-1:0]      res
);

  logic signed [CH_W-1:0]   p1;
  logic signed [CH_W-1:0]   c1;
  logic signed [WIDE_W-1:0] prod;
  logic signed [WIDE_W-1:0] cw;
  logic signed [WIDE_W-1:0] pw;
  logic signed [CH_W+1:0]   inv_a;
  logic signed [WIDE_W-1:0] r_next;
  logic signed [CH_W-1:0]   ar [NUM_W-1];
  logic signed [CH_W-1:0]   div_q;

  assign inv_a = ONE_S - (CH_W+2)'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= p;
      c1   <= c;
      prod <= WIDE_W'(p * c);
      cw   <= WIDE_W'(c * a);
      pw   <= WIDE_W'((CH_W+2)'(p) * inv_a);
    end
  end

  always_comb begin
    case (mode)
      MODE_SUB:   r_next = WIDE_W'(p1) - WIDE_W'(c1);
      MODE_MUL:   r_next = (prod + HALF_W) >>> FRAC_BITS;
      MODE_BLEND: r_next = (cw + pw + HALF_W) >>> FRAC_BITS;
      MODE_SOLID: r_next = WIDE_W'(c1);
      default:    r_next = WIDE_W'(p1) + WIDE_W'(c1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar[0] <= sat_wide(r_next);
      for (int i = 1; i < NUM_W - 1; i++) begin
        ar[i] <= ar[i-1];
      end
      res <= (mode == MODE_DIV) ? div_q : ar[NUM_W-2];
    end
  end

  lbc_div u_div (
    .clk (clk),
    .en  (en),
    .p   (p),
    .c   (c),
    .q   (div_q)
  );

endmodule
`default_nettype wire

// ===== rtl/layer_bracket_compositor.sv =====
// Channel     | dir | fields (tdata low bit up)
// s_*         | in  | parent r,g,b,a, child r,g,b,a (24b each); tlast = last_pixel
// m_*         | out | out r,g,b,a (24b each); tlast = out_last
// cfg_*       | in  | blend_mode, 3 bits
// One pixel per cycle unless m_tready stalls; pipeline depth LAT is set by the
// one-bit-per-stage divider. Synchronous reset empties the pipeline and
// sets blend_mode to add. A stall on m_tready freezes every stage.
// Depends on lbc_pkg, lbc_chan, layer_bracket_compositor_assert.svh.
`default_nettype none
`include "layer_bracket_compositor_assert.svh"
module layer_bracket_compositor import lbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [8*CH_W-1:0] s_tdata,  // p r,g,b,a, c r,g,b,a
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [4*CH_W-1:0]      m_tdata,  // out r,g,b,a
  output logic                   m_tlast,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_wdata
);

  mode_t                  blend_mode;
  logic                   en;
  logic [LAT-1:0]         vp;
  logic [LAT-1:0]         lp;
  logic signed [CH_W-1:0] ip [4];
  logic signed [CH_W-1:0] ic [4];
  logic signed [CH_W-1:0] res [4];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vp[LAT-1];
  assign m_tlast  = lp[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_ADD;
    end else if (cfg_we) begin
      blend_mode <= mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lp <= {lp[LAT-2:0], s_tlast};
      for (int k = 0; k < 4; k++) begin
        ip[k] <= s_tdata[k*CH_W +: CH_W];
        ic[k] <= s_tdata[(4+k)*CH_W +: CH_W];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_ch
    lbc_chan u_chan (
      .clk  (clk),
      .en   (en),
      .mode (blend_mode),
      .p    (ip[k]),
      .c    (ic[k]),
      .a    (ic[3]),
      .res  (res[k])
    );
    assign m_tdata[k*CH_W +: CH_W] = res[k];
  end

  `LBC_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, vp[0])
  `LBC_ASSERT_NXT(a_stall_freezes, !s_tready, $stable(vp) && $stable(lp))
  `LBC_ASSERT_NXT_RST(a_reset_empty, rst, vp == '0 && blend_mode == MODE_ADD)

endmodule
`default_nettype wire
